// ===== rtl/core/gbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gbp_pkg;
    localparam int NUM_SLOTS  = 16;
    localparam int SLOT_BYTES = 256;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);
    localparam int OFF_W      = $clog2(SLOT_BYTES);
    localparam int SIZE_W     = OFF_W + 1;
    localparam int ADDR_W     = SLOT_W + OFF_W;

    localparam logic [2:0] CMD_ALLOC = 3'd0;
    localparam logic [2:0] CMD_WRITE = 3'd1;
    localparam logic [2:0] CMD_SUM   = 3'd2;
    localparam logic [2:0] CMD_MOVE  = 3'd3;
    localparam logic [2:0] CMD_FREE  = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_STALE     = 3'd1;
    localparam logic [2:0] ST_BOUNDS    = 3'd2;
    localparam logic [2:0] ST_SAME      = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_TOO_LARGE = 3'd5;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } store_req_t;
endpackage
`default_nettype wire

// ===== rtl/core/gbp_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gbp_store
    import gbp_pkg::*;
(
    input  wire logic       clk,
    input  wire store_req_t req,
    output logic [7:0]      rd_data
);
    logic [7:0] mem [0:NUM_SLOTS*SLOT_BYTES-1];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/generational_buffer_pool.sv =====
// generational_buffer_pool: byte buffer pool named by (slot, generation) handles
// input channel: command with handle, destination handle, size/offset and byte,
// taken on in_valid && in_ready; output channel: status, new handle, value and
// live totals, one result item per command, taken on out_valid && out_ready
// commands decode combinationally against the slot tables held in flip-flops;
// byte work goes through a single-port-per-direction byte store, one byte a cycle
// write byte, free, unknown codes, failed checks: result with no byte loop
// allocate: zero fill of size bytes, one store write a cycle
// sum: one store read a cycle, each byte added when its registered read returns
// move: one source byte read a cycle, each written behind the destination;
// sum and move skip the byte loop when the source is empty
// only one item is in work at a time; in_ready is high only while idle with the
// result register empty, so the next item is taken the cycle after the result
// reset clears the slot tables and totals at once; the byte store is not
// cleared, allocate zero-fills every byte a buffer owns
// while the receiver stalls the result item and live totals hold and in_ready
// stays low
`timescale 1ns / 1ps
`default_nettype none
module generational_buffer_pool
    import gbp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  command,
    input  wire logic [3:0]  slot_index,
    input  wire logic [31:0] slot_generation,
    input  wire logic [3:0]  dest_index,
    input  wire logic [31:0] dest_generation,
    input  wire logic [8:0]  size_or_offset,
    input  wire logic [7:0]  byte_value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [3:0]       handle_index,
    output logic [31:0]      handle_generation,
    output logic [15:0]      result_value,
    output logic [4:0]       live_slots,
    output logic [12:0]      live_bytes
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [31:0]       gen_reg  [NUM_SLOTS];
    logic              live_reg [NUM_SLOTS];
    logic [SIZE_W-1:0] size_reg [NUM_SLOTS];
    logic [4:0]        count_reg;
    logic [12:0]       total_reg;

    logic [2:0]        op_reg;
    logic [SLOT_W-1:0] src_reg, dst_reg;
    logic [SIZE_W-1:0] len_reg, base_reg, k_reg;
    logic              rd_pend_reg;
    logic [15:0]       acc_reg;

    logic [2:0]  r_status_reg;
    logic [3:0]  r_idx_reg;
    logic [31:0] r_gen_reg;
    logic [15:0] r_val_reg;
    logic        out_valid_reg;

    store_req_t req;
    logic [7:0] rd_data;

    gbp_store u_store (.clk(clk), .req(req), .rd_data(rd_data));

    logic              s_ok, d_ok, have_free;
    logic [SLOT_W-1:0] si, di, free_slot;
    logic [SIZE_W:0]   joined;
    logic              in_fire;

    assign si = slot_index[SLOT_W-1:0];
    assign di = dest_index[SLOT_W-1:0];
    assign s_ok = (32'(slot_index) < NUM_SLOTS) && live_reg[si]
        && (gen_reg[si] == slot_generation);
    assign d_ok = (32'(dest_index) < NUM_SLOTS) && live_reg[di]
        && (gen_reg[di] == dest_generation);
    assign joined = {1'b0, size_reg[si]} + {1'b0, size_reg[di]};

    always_comb
    begin
        have_free = 1'b0;
        free_slot = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!live_reg[i])
            begin
                have_free = 1'b1;
                free_slot = SLOT_W'(i);
            end
        end
    end

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign status            = r_status_reg;
    assign handle_index      = r_idx_reg;
    assign handle_generation = r_gen_reg;
    assign result_value      = r_val_reg;
    assign live_slots        = count_reg;
    assign live_bytes        = total_reg;

    logic loop_last;
    assign loop_last = (k_reg == len_reg);

    always_comb
    begin
        req = '0;
        if (in_fire && command == CMD_WRITE && s_ok
            && size_or_offset < size_reg[si])
        begin
            req.wr_en   = 1'b1;
            req.wr_addr = {si, size_or_offset[OFF_W-1:0]};
            req.wr_data = byte_value;
        end
        if (state_reg == S_RUN)
        begin
            if (op_reg == CMD_ALLOC && !loop_last)
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = {dst_reg, k_reg[OFF_W-1:0]};
                req.wr_data = 8'd0;
            end
            if ((op_reg == CMD_SUM || op_reg == CMD_MOVE) && !loop_last)
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = {src_reg, k_reg[OFF_W-1:0]};
            end
            if (op_reg == CMD_MOVE && rd_pend_reg)
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = {dst_reg, base_reg[OFF_W-1:0]};
                req.wr_data = rd_data;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_fire) state_next = S_RUN;
            S_RUN:
                if (loop_last && !rd_pend_reg && !out_valid_reg) state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            total_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            op_reg        <= '0;
            src_reg       <= '0;
            dst_reg       <= '0;
            len_reg       <= '0;
            base_reg      <= '0;
            k_reg         <= '0;
            acc_reg       <= '0;
            r_status_reg  <= '0;
            r_idx_reg     <= '0;
            r_gen_reg     <= '0;
            r_val_reg     <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                gen_reg[i]  <= '0;
                live_reg[i] <= 1'b0;
                size_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                    if (in_fire)
                    begin
                        op_reg       <= command;
                        src_reg      <= si;
                        k_reg        <= '0;
                        len_reg      <= '0;
                        acc_reg      <= '0;
                        r_status_reg <= ST_OK;
                        r_idx_reg    <= '0;
                        r_gen_reg    <= '0;
                        r_val_reg    <= '0;
                        case (command)
                            CMD_ALLOC:
                                if (size_or_offset > SIZE_W'(SLOT_BYTES))
                                    r_status_reg <= ST_TOO_LARGE;
                                else if (!have_free)
                                    r_status_reg <= ST_FULL;
                                else
                                begin
                                    gen_reg[free_slot]  <= gen_reg[free_slot] + 32'd1;
                                    live_reg[free_slot] <= 1'b1;
                                    size_reg[free_slot] <= size_or_offset;
                                    count_reg <= count_reg + 5'd1;
                                    total_reg <= total_reg + 13'(size_or_offset);
                                    dst_reg   <= free_slot;
                                    len_reg   <= size_or_offset;
                                    r_idx_reg <= 4'(free_slot);
                                    r_gen_reg <= gen_reg[free_slot] + 32'd1;
                                end
                            CMD_WRITE:
                                if (!s_ok)
                                    r_status_reg <= ST_STALE;
                                else if (size_or_offset >= size_reg[si])
                                    r_status_reg <= ST_BOUNDS;
                            CMD_SUM:
                                if (!s_ok)
                                    r_status_reg <= ST_STALE;
                                else
                                    len_reg <= size_reg[si];
                            CMD_MOVE:
                                if (!s_ok || !d_ok)
                                    r_status_reg <= ST_STALE;
                                else if (si == di)
                                    r_status_reg <= ST_SAME;
                                else if (joined > (SIZE_W+1)'(SLOT_BYTES))
                                    r_status_reg <= ST_TOO_LARGE;
                                else
                                begin
                                    len_reg        <= size_reg[si];
                                    dst_reg        <= di;
                                    base_reg       <= size_reg[di];
                                    size_reg[di]   <= joined[SIZE_W-1:0];
                                    size_reg[si]   <= '0;
                                    live_reg[si]   <= 1'b0;
                                    count_reg      <= count_reg - 5'd1;
                                    r_val_reg      <= 16'(joined);
                                end
                            CMD_FREE:
                                if (!s_ok)
                                    r_status_reg <= ST_STALE;
                                else
                                begin
                                    total_reg    <= total_reg - 13'(size_reg[si]);
                                    size_reg[si] <= '0;
                                    live_reg[si] <= 1'b0;
                                    count_reg    <= count_reg - 5'd1;
                                end
                            default: ;
                        endcase
                    end
                S_RUN:
                begin
                    rd_pend_reg <= !loop_last && (op_reg == CMD_SUM || op_reg == CMD_MOVE);
                    if (!loop_last)
                    begin
                        k_reg <= k_reg + SIZE_W'(1);
                    end
                    if (rd_pend_reg)
                    begin
                        if (op_reg == CMD_SUM)
                            acc_reg <= acc_reg + 16'(rd_data);
                        if (op_reg == CMD_MOVE)
                            base_reg <= base_reg + SIZE_W'(1);
                    end
                end
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    if (op_reg == CMD_SUM)
                        r_val_reg <= acc_reg;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== test/generational_buffer_pool_checker.sv =====
`timescale 1ns / 1ps
module generational_buffer_pool_checker
    import gbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  command,
    input  logic [3:0]  slot_index,
    input  logic [31:0] slot_generation,
    input  logic [3:0]  dest_index,
    input  logic [31:0] dest_generation,
    input  logic [8:0]  size_or_offset,
    input  logic [7:0]  byte_value,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  status,
    input  logic [3:0]  handle_index,
    input  logic [31:0] handle_generation,
    input  logic [15:0] result_value,
    input  logic [4:0]  live_slots,
    input  logic [12:0] live_bytes,
    output int          error_count,
    output int          pending_count
);
    typedef struct packed {
        logic [2:0]  st;
        logic [3:0]  hidx;
        logic [31:0] hgen;
        logic [15:0] value;
        logic [4:0]  slots;
        logic [12:0] bytes;
    } pool_result_t;

    logic [31:0] gen_table [NUM_SLOTS];
    logic        live      [NUM_SLOTS];
    logic [8:0]  sizes     [NUM_SLOTS];
    logic [7:0]  bytes_mem [NUM_SLOTS*SLOT_BYTES];
    logic [4:0]  live_total;
    logic [12:0] byte_sum_total;
    pool_result_t expected_results[$];

    function automatic logic handle_live(logic [3:0] idx, logic [31:0] gen);
        return live[idx] && gen_table[idx] == gen;
    endfunction

    task automatic apply_command(output pool_result_t r);
        int s;
        logic [15:0] acc;
        logic [8:0] n;
        logic [8:0] d;
        r = '0;
        r.st = ST_OK;
        case (command)
            CMD_ALLOC:
            begin
                s = 0;
                while (s < NUM_SLOTS && live[s])
                    s++;
                if (size_or_offset > SLOT_BYTES)
                    r.st = ST_TOO_LARGE;
                else if (s >= NUM_SLOTS)
                    r.st = ST_FULL;
                else
                begin
                    gen_table[s] = gen_table[s] + 1;
                    live[s] = 1'b1;
                    sizes[s] = size_or_offset;
                    for (int k = 0; k < size_or_offset; k++)
                        bytes_mem[s*SLOT_BYTES+k] = 8'd0;
                    live_total++;
                    byte_sum_total += size_or_offset;
                    r.hidx = 4'(s);
                    r.hgen = gen_table[s];
                end
            end
            CMD_WRITE:
            begin
                if (!handle_live(slot_index, slot_generation))
                    r.st = ST_STALE;
                else if (size_or_offset >= sizes[slot_index])
                    r.st = ST_BOUNDS;
                else
                    bytes_mem[slot_index*SLOT_BYTES+size_or_offset] = byte_value;
            end
            CMD_SUM:
            begin
                if (!handle_live(slot_index, slot_generation))
                    r.st = ST_STALE;
                else
                begin
                    acc = '0;
                    for (int k = 0; k < sizes[slot_index]; k++)
                        acc += bytes_mem[slot_index*SLOT_BYTES+k];
                    r.value = acc;
                end
            end
            CMD_MOVE:
            begin
                if (!handle_live(slot_index, slot_generation)
                    || !handle_live(dest_index, dest_generation))
                    r.st = ST_STALE;
                else if (slot_index == dest_index)
                    r.st = ST_SAME;
                else if (sizes[slot_index] + sizes[dest_index] > SLOT_BYTES)
                    r.st = ST_TOO_LARGE;
                else
                begin
                    n = sizes[slot_index];
                    d = sizes[dest_index];
                    for (int k = 0; k < n; k++)
                        bytes_mem[dest_index*SLOT_BYTES+d+k] =
                            bytes_mem[slot_index*SLOT_BYTES+k];
                    sizes[dest_index] = d + n;
                    sizes[slot_index] = '0;
                    live[slot_index] = 1'b0;
                    live_total--;
                    r.value = d + n;
                end
            end
            CMD_FREE:
            begin
                if (!handle_live(slot_index, slot_generation))
                    r.st = ST_STALE;
                else
                begin
                    byte_sum_total -= sizes[slot_index];
                    sizes[slot_index] = '0;
                    live[slot_index] = 1'b0;
                    live_total--;
                end
            end
            default:
            begin
            end
        endcase
        r.slots = live_total;
        r.bytes = byte_sum_total;
    endtask

    initial
    begin
        error_count = 0;
        pending_count = 0;
        live_total = '0;
        byte_sum_total = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            gen_table[i] = '0;
            live[i] = 1'b0;
            sizes[i] = '0;
        end
    end

    always @(posedge clk)
    begin
        pool_result_t want;
        pool_result_t got;
        if (rst_n && in_valid && in_ready)
        begin
            apply_command(want);
            expected_results.push_back(want);
        end
        if (rst_n && out_valid && out_ready)
        begin
            got = {status, handle_index, handle_generation, result_value,
                   live_slots, live_bytes};
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none expected, actual %h", $time, got);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.st !== want.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
                    error_count++;
                end
                if (got.hidx !== want.hidx)
                begin
                    $display("%0t: handle_index expected %0d actual %0d",
                             $time, want.hidx, got.hidx);
                    error_count++;
                end
                if (got.hgen !== want.hgen)
                begin
                    $display("%0t: handle_generation expected %h actual %h",
                             $time, want.hgen, got.hgen);
                    error_count++;
                end
                if (got.value !== want.value)
                begin
                    $display("%0t: result_value expected %0d actual %0d",
                             $time, want.value, got.value);
                    error_count++;
                end
                if (got.slots !== want.slots)
                begin
                    $display("%0t: live_slots expected %0d actual %0d",
                             $time, want.slots, got.slots);
                    error_count++;
                end
                if (got.bytes !== want.bytes)
                begin
                    $display("%0t: live_bytes expected %0d actual %0d",
                             $time, want.bytes, got.bytes);
                    error_count++;
                end
            end
        end
        pending_count = expected_results.size();
    end
endmodule

// ===== test/generational_buffer_pool_test.sv =====
`timescale 1ns / 1ps
module generational_buffer_pool_test;
    import gbp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  command;
    logic [3:0]  slot_index;
    logic [31:0] slot_generation;
    logic [3:0]  dest_index;
    logic [31:0] dest_generation;
    logic [8:0]  size_or_offset;
    logic [7:0]  byte_value;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [3:0]  handle_index;
    logic [31:0] handle_generation;
    logic [15:0] result_value;
    logic [4:0]  live_slots;
    logic [12:0] live_bytes;
    int          error_count;
    int          pending_count;
    int          idle_cycles;
    int          items_sent;
    int          results_seen;
    bit          quiet_mode;
    bit          hold_sink;
    bit          stim_done;

    // handles the stimulus believes are live
    logic [31:0] known_gen  [16];
    bit          known_live [16];
    int          known_size [16];

    generational_buffer_pool u_top (.*);

    generational_buffer_pool_checker u_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic send_item(logic [2:0] c, logic [3:0] si, logic [31:0] sg,
                             logic [3:0] di, logic [31:0] dg, logic [8:0] arg,
                             logic [7:0] b);
        int gap;
        if (!quiet_mode && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= c;
        slot_index <= si;
        slot_generation <= sg;
        dest_index <= di;
        dest_generation <= dg;
        size_or_offset <= arg;
        byte_value <= b;
        // in_ready comes only from registers, so its value at the falling edge decides the next edge
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        items_sent++;
        // track handle state from what a correct block does
        if (c == CMD_ALLOC && arg <= SLOT_BYTES)
        begin
            for (int s = 0; s < 16; s++)
            begin
                if (!known_live[s])
                begin
                    known_live[s] = 1'b1;
                    known_gen[s] = known_gen[s] + 1;
                    known_size[s] = arg;
                    break;
                end
            end
        end
        else if (c == CMD_FREE && known_live[si] && known_gen[si] == sg)
            known_live[si] = 1'b0;
        else if (c == CMD_MOVE && known_live[si] && known_gen[si] == sg
                 && known_live[di] && known_gen[di] == dg && si != di
                 && known_size[si] + known_size[di] <= SLOT_BYTES)
        begin
            known_size[di] += known_size[si];
            known_live[si] = 1'b0;
        end
    endtask

    function automatic logic [3:0] pick_live();
        int s;
        s = $urandom_range(0, 15);
        for (int k = 0; k < 16; k++)
            if (known_live[(s + k) % 16])
                return 4'((s + k) % 16);
        return 4'(s);
    endfunction

    task automatic random_item();
        logic [3:0] a;
        logic [3:0] d;
        logic [31:0] ga;
        logic [31:0] gd;
        int pick;
        a = pick_live();
        d = pick_live();
        if ($urandom_range(0, 3) == 0)
            d = 4'($urandom_range(0, 15));
        ga = known_gen[a];
        gd = known_gen[d];
        if ($urandom_range(0, 9) == 0)
            ga = $urandom;
        if ($urandom_range(0, 9) == 0)
            gd = ga - 1;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            send_item(CMD_ALLOC, 4'($urandom), $urandom, 4'($urandom), $urandom,
                      9'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 511)
                                                     : $urandom_range(0, 24)),
                      8'($urandom));
        else if (pick < 55)
            send_item(CMD_WRITE, a, ga, 4'($urandom), $urandom,
                      9'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 511)
                          : $urandom_range(0, (known_size[a] > 0) ? known_size[a] : 1)),
                      8'($urandom));
        else if (pick < 70)
            send_item(CMD_SUM, a, ga, 4'($urandom), $urandom, 9'($urandom),
                      8'($urandom));
        else if (pick < 82)
            send_item(CMD_MOVE, a, ga, d, gd, 9'($urandom), 8'($urandom));
        else if (pick < 96)
            send_item(CMD_FREE, a, ga, 4'($urandom), $urandom, 9'($urandom),
                      8'($urandom));
        else
            send_item(3'($urandom_range(5, 7)), 4'($urandom), $urandom, 4'($urandom),
                      $urandom, 9'($urandom), 8'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        command = '0;
        slot_index = '0;
        slot_generation = '0;
        dest_index = '0;
        dest_generation = '0;
        size_or_offset = '0;
        byte_value = '0;
        items_sent = 0;
        quiet_mode = 1'b0;
        hold_sink = 1'b0;
        stim_done = 1'b0;
        for (int i = 0; i < 16; i++)
        begin
            known_gen[i] = '0;
            known_live[i] = 1'b0;
            known_size[i] = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every command, each error path
        send_item(CMD_ALLOC, 4'd0, '0, 4'd0, '0, 9'd257, 8'd0);
        send_item(CMD_ALLOC, 4'd0, '0, 4'd0, '0, 9'd511, 8'd0);
        send_item(CMD_ALLOC, 4'd0, '0, 4'd0, '0, 9'd256, 8'd0);
        send_item(CMD_WRITE, 4'd0, 32'd1, 4'd0, '0, 9'd255, 8'hff);
        send_item(CMD_WRITE, 4'd0, 32'd1, 4'd0, '0, 9'd0, 8'h80);
        send_item(CMD_WRITE, 4'd0, 32'd1, 4'd0, '0, 9'd256, 8'h01);
        send_item(CMD_SUM, 4'd0, 32'd1, 4'd0, '0, '0, '0);
        send_item(CMD_SUM, 4'd15, 32'hffff_ffff, 4'd0, '0, '0, '0);
        send_item(CMD_ALLOC, 4'd0, '0, 4'd0, '0, 9'd0, 8'd0);
        send_item(CMD_ALLOC, 4'd0, '0, 4'd0, '0, 9'd3, 8'd0);
        send_item(CMD_MOVE, 4'd0, 32'd1, 4'd0, 32'd1, '0, '0);
        send_item(CMD_MOVE, 4'd0, 32'd1, 4'd2, 32'd1, '0, '0);
        send_item(CMD_MOVE, 4'd1, 32'd1, 4'd2, 32'd1, '0, '0);
        send_item(CMD_MOVE, 4'd2, 32'd1, 4'd0, 32'd0, '0, '0);
        send_item(CMD_FREE, 4'd0, 32'd1, 4'd0, '0, '0, '0);
        send_item(CMD_FREE, 4'd0, 32'd1, 4'd0, '0, '0, '0);
        send_item(3'd7, 4'hf, 32'hffff_ffff, 4'hf, 32'hffff_ffff, 9'h1ff, 8'hff);
        for (int i = 0; i < 17; i++)
            send_item(CMD_ALLOC, '0, '0, '0, '0, 9'd1, 8'd0);

        // receiver holds off while items keep coming; the sink ends the hold
        hold_sink = 1'b1;
        for (int i = 0; i < 6; i++)
            random_item();

        for (int i = 0; i < 450; i++)
        begin
            if (i == 380)
                quiet_mode = 1'b1;
            random_item();
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // result side, with one long hold-off
    initial
    begin
        int gap;
        results_seen = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_sink)
            begin
                out_ready <= 1'b0;
                repeat (600) @(posedge clk);
                hold_sink = 1'b0;
            end
            else if (!quiet_mode && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 13);
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
                if (out_valid && out_ready)
                    results_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        idle_cycles = 0;
        wait (stim_done);
        while (pending_count != 0 && idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        if (pending_count == 0)
            repeat (300) @(posedge clk);
        $display("covered %0d commands: allocate, write, sum, move, free and unknown codes,",
                 items_sent);
        $display("with stale handles, bounds, same-slot and full-pool cases and long stalls");
        if (pending_count == 0 && error_count == 0)
            $display("generational_buffer_pool_test: done, clean");
        else
            $display("generational_buffer_pool_test: done, errors");
        $finish;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT && !stim_done);
        $display("generational_buffer_pool_test: done, errors");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/gbp_pkg.sv
rtl/core/gbp_store.sv
rtl/core/generational_buffer_pool.sv
test/generational_buffer_pool_checker.sv
test/generational_buffer_pool_test.sv
